// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the RTL of the nearest grid point selector.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hdl/ngps_pkg.sv -----
// Package for the nearest grid point selector: field widths, command codes and
// the control struct of the sorting cells. No dependencies.
package ngps_pkg;

  localparam int CMD_W      = 2;
  localparam int LAT_W      = 24;
  localparam int LON_W      = 25;
  localparam int DSQ_W      = 51;
  localparam int ROOT_W     = 26;
  localparam int DIST_W     = 25;
  localparam int INDEX_W    = 8;
  localparam int RANK_W     = 3;
  localparam int KCFG_W     = 4;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 40;

  localparam logic [KCFG_W-1:0] KCFG_RESET = 4'd8;

  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  typedef struct packed {
    logic clear;
    logic insert;
    logic shift;
  } cell_ctl_t;

endpackage

// ----- hdl/ngps_cell.sv -----
// One cell of the sorted nearest-point list. Holds one squared distance and
// its point index. Depends on ngps_pkg.
module ngps_cell #(
  parameter int IW = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ngps_pkg::cell_ctl_t       ctl,
  input  logic                      enable,
  input  logic [ngps_pkg::DSQ_W-1:0] new_dsq,
  input  logic [IW-1:0]             new_idx,
  input  logic                      left_take,
  input  logic                      left_valid,
  input  logic [ngps_pkg::DSQ_W-1:0] left_dsq,
  input  logic [IW-1:0]             left_idx,
  input  logic                      right_valid,
  input  logic [ngps_pkg::DSQ_W-1:0] right_dsq,
  input  logic [IW-1:0]             right_idx,
  output logic                      valid,
  output logic [ngps_pkg::DSQ_W-1:0] dsq,
  output logic [IW-1:0]             idx,
  output logic                      take
);

  // A new point lands here when this slot is free or holds a strictly larger
  // distance; an equal distance keeps the earlier point ahead.
  assign take = enable && (!valid || (new_dsq < dsq));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.clear) begin
      valid <= 1'b0;
    end else if (ctl.shift) begin
      valid <= right_valid;
    end else if (ctl.insert && take) begin
      valid <= left_take ? left_valid : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      dsq <= right_dsq;
      idx <= right_idx;
    end else if (ctl.insert && take) begin
      if (left_take) begin
        dsq <= left_dsq;
        idx <= left_idx;
      end else begin
        dsq <= new_dsq;
        idx <= new_idx;
      end
    end
  end

endmodule

// ----- hdl/ngps_sqrt.sv -----
// Iterative integer square root, one result bit per cycle, saturated to the
// distance width. Depends on ngps_pkg.
module ngps_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ngps_pkg::DSQ_W-1:0]  radicand,
  output logic                        busy,
  output logic                        done,
  output logic [ngps_pkg::DIST_W-1:0] root
);

  localparam int RW  = ngps_pkg::ROOT_W;
  localparam int SW  = 2 * RW;
  localparam int CNW = $clog2(RW + 1);

  logic [SW-1:0]   rad;
  logic [RW:0]     rem;
  logic [RW-1:0]   res;
  logic [CNW-1:0]  cnt;
  logic [RW+2:0]   sh;
  logic [RW+2:0]   trial;
  logic [RW+2:0]   diff;
  logic            fits;

  assign sh    = {rem, rad[SW-1:SW-2]};
  assign trial = {1'b0, res, 2'b01};
  assign diff  = sh - trial;
  assign fits  = (sh >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNW'(1);
        if (cnt == CNW'(RW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad <= SW'(radicand);
      rem <= '0;
      res <= '0;
    end else if (busy) begin
      rad <= {rad[SW-3:0], 2'b00};
      if (fits) begin
        rem <= diff[RW:0];
        res <= {res[RW-2:0], 1'b1};
      end else begin
        rem <= sh[RW:0];
        res <= {res[RW-2:0], 1'b0};
      end
    end
  end

  assign root = res[RW-1] ? '1 : res[ngps_pkg::DIST_W-1:0];

endmodule

// ----- hdl/nearest_grid_point_select.sv -----
// Top level of the nearest grid point selector: point store, distance pipeline,
// sorting cell chain and result sequencer. Depends on ngps_pkg, ngps_cell,
// ngps_sqrt and assert_macros.svh.
//
// Usage. Items arrive on the s_axis channel: tuser carries the command (append a
// point, clear the table, query), tdata the latitude and longitude. Append and
// clear keep the block idle, so it is ready again in the next cycle. A query
// reads every stored point in load order through a four-stage distance pipeline
// into a chain of MAX_NEAREST sorting cells, then takes the kept points out of
// the chain one at a time through a bit-serial square root unit.
// Each found result waits for the root unit to work through its 26 root steps
// before the hand-off to the output register; an empty result skips the root
// unit. The root unit sets the per-result cost.
// Results leave on m_axis through an output register: tuser is the found flag,
// tlast marks the final result of a query. When the receiver stalls, the result
// holds in the register and the sequencer waits before loading the next one; a
// new input item is taken once the query has handed over its final result.
// The user must write the k_nearest register through cfg_we and cfg_wdata only
// while idle; the block itself does not enforce this.
// Reset empties the table, sets k_nearest to 8 and drops any pending result.
`include "assert_macros.svh"

module nearest_grid_point_select #(
  parameter int MAX_POINTS  = 256,
  parameter int MAX_NEAREST = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // lat [23:0], lon [48:24], zero fill [55:49]
  input  logic [ngps_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // cmd [1:0]
  input  logic [ngps_pkg::CMD_W-1:0]       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // grid_index [7:0], distance [32:8], rank [35:33], zero fill [39:36]
  output logic [ngps_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // found [0]
  output logic [0:0]                       m_axis_tuser,
  output logic                             m_axis_tlast,
  input  logic                             cfg_we,
  input  logic [ngps_pkg::KCFG_W-1:0]      cfg_wdata
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int KW = $clog2(MAX_NEAREST + 1);
  localparam int RW = (MAX_NEAREST > 1) ? $clog2(MAX_NEAREST) : 1;
  localparam int LAT_W = ngps_pkg::LAT_W;
  localparam int LON_W = ngps_pkg::LON_W;
  localparam int DSQ_W = ngps_pkg::DSQ_W;
  localparam int PT_W  = LAT_W + LON_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_ROOT  = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;
  localparam logic [2:0] S_SEND  = 3'd5;

  logic [2:0]                  state;
  logic [CW-1:0]               point_count;
  logic [ngps_pkg::KCFG_W-1:0] k_nearest;
  logic [KW-1:0]               k_eff;
  logic [LAT_W-1:0]            q_lat;
  logic [LON_W-1:0]            q_lon;
  logic [CW-1:0]               scan_cnt;

  logic [PT_W-1:0]             mem [MAX_POINTS];
  logic [PT_W-1:0]             rd_data;
  logic                        rd_v;
  logic [AW-1:0]               rd_idx;

  logic [LAT_W:0]              dlat;
  logic [LON_W:0]              dlon;
  logic [LAT_W:0]              abs_lat;
  logic [LON_W:0]              abs_lon;
  logic                        v1;
  logic [LAT_W-1:0]            a_lat;
  logic [LON_W-1:0]            a_lon;
  logic [AW-1:0]               idx1;
  logic [2*LAT_W-1:0]          sq_lat_w;
  logic [2*LON_W-1:0]          sq_lon_w;
  logic                        v2;
  logic [2*LAT_W-1:0]          sq_lat;
  logic [2*LON_W-1:0]          sq_lon;
  logic [AW-1:0]               idx2;
  logic                        v3;
  logic [DSQ_W-1:0]            dsq3;
  logic [AW-1:0]               idx3;

  logic                        in_xfer;
  logic                        wr_en;
  logic                        query_start;
  logic                        out_free;
  ngps_pkg::cell_ctl_t         cell_ctl;

  logic                        c_valid [MAX_NEAREST+2];
  logic [DSQ_W-1:0]            c_dsq   [MAX_NEAREST+2];
  logic [AW-1:0]               c_idx   [MAX_NEAREST+2];
  logic                        c_take  [MAX_NEAREST+2];
  logic [MAX_NEAREST-1:0]      cell_valid;

  logic                        sq_start;
  logic                        sq_busy;
  logic                        sq_done;
  logic [ngps_pkg::DIST_W-1:0] sq_root;

  logic [RW-1:0]               rank_cnt;
  logic [AW-1:0]               cur_idx;
  logic                        cur_last;
  logic                        cur_found;
  logic [AW+ngps_pkg::INDEX_W-1:0] idx_wide;
  logic [RW+ngps_pkg::RANK_W-1:0]  rank_wide;

  logic [ngps_pkg::INDEX_W-1:0] out_idx;
  logic [ngps_pkg::DIST_W-1:0]  out_dist;
  logic [ngps_pkg::RANK_W-1:0]  out_rank;
  logic                         out_found;
  logic                         out_last;

  logic                         in_scan;
  logic                         cells_packed;

  assign s_axis_tready = (state == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign wr_en         = in_xfer && (s_axis_tuser == ngps_pkg::CMD_APPEND) &&
                         (point_count < CW'(MAX_POINTS));
  assign query_start   = in_xfer && (s_axis_tuser == ngps_pkg::CMD_QUERY);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign k_eff = (32'(k_nearest) > MAX_NEAREST) ? KW'(MAX_NEAREST) : KW'(k_nearest);

  assign sq_start = (state == S_ROOT) && c_valid[1];

  assign cell_ctl.clear  = query_start;
  assign cell_ctl.insert = v3;
  assign cell_ctl.shift  = sq_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_nearest <= ngps_pkg::KCFG_RESET;
    end else if (cfg_we) begin
      k_nearest <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[point_count[AW-1:0]] <= s_axis_tdata[PT_W-1:0];
    end
    rd_data <= mem[scan_cnt[AW-1:0]];
    rd_idx  <= scan_cnt[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (query_start) begin
      q_lat <= s_axis_tdata[LAT_W-1:0];
      q_lon <= s_axis_tdata[PT_W-1:LAT_W];
    end
  end

  assign dlat    = {q_lat[LAT_W-1], q_lat} - {rd_data[LAT_W-1], rd_data[LAT_W-1:0]};
  assign dlon    = {q_lon[LON_W-1], q_lon} - {rd_data[PT_W-1], rd_data[PT_W-1:LAT_W]};
  assign abs_lat = dlat[LAT_W] ? -dlat : dlat;
  assign abs_lon = dlon[LON_W] ? -dlon : dlon;
  assign sq_lat_w = a_lat * a_lat;
  assign sq_lon_w = a_lon * a_lon;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
    end else begin
      rd_v <= (state == S_SCAN);
      v1   <= rd_v;
      v2   <= v1;
      v3   <= v2;
    end
  end

  always_ff @(posedge clk) begin
    a_lat  <= abs_lat[LAT_W-1:0];
    a_lon  <= abs_lon[LON_W-1:0];
    idx1   <= rd_idx;
    sq_lat <= sq_lat_w;
    sq_lon <= sq_lon_w;
    idx2   <= idx1;
    dsq3   <= DSQ_W'(sq_lat) + DSQ_W'(sq_lon);
    idx3   <= idx2;
  end

  assign c_valid[0] = 1'b0;
  assign c_dsq[0]   = '0;
  assign c_idx[0]   = '0;
  assign c_take[0]  = 1'b0;
  assign c_valid[MAX_NEAREST+1] = 1'b0;
  assign c_dsq[MAX_NEAREST+1]   = '0;
  assign c_idx[MAX_NEAREST+1]   = '0;
  assign c_take[MAX_NEAREST+1]  = 1'b0;

  for (genvar j = 0; j < MAX_NEAREST; j++) begin : g_cell
    ngps_cell #(
      .IW(AW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (cell_ctl),
      .enable     (k_eff > KW'(j)),
      .new_dsq    (dsq3),
      .new_idx    (idx3),
      .left_take  (c_take[j]),
      .left_valid (c_valid[j]),
      .left_dsq   (c_dsq[j]),
      .left_idx   (c_idx[j]),
      .right_valid(c_valid[j+2]),
      .right_dsq  (c_dsq[j+2]),
      .right_idx  (c_idx[j+2]),
      .valid      (c_valid[j+1]),
      .dsq        (c_dsq[j+1]),
      .idx        (c_idx[j+1]),
      .take       (c_take[j+1])
    );
    assign cell_valid[j] = c_valid[j+1];
  end

  ngps_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (sq_start),
    .radicand(c_dsq[1]),
    .busy    (sq_busy),
    .done    (sq_done),
    .root    (sq_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      point_count <= '0;
      scan_cnt    <= '0;
      rank_cnt    <= '0;
      cur_last    <= 1'b0;
      cur_found   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            case (s_axis_tuser)
              ngps_pkg::CMD_APPEND: begin
                if (wr_en) begin
                  point_count <= point_count + CW'(1);
                end
              end
              ngps_pkg::CMD_CLEAR: begin
                point_count <= '0;
              end
              ngps_pkg::CMD_QUERY: begin
                scan_cnt <= '0;
                rank_cnt <= '0;
                state    <= (point_count == '0) ? S_ROOT : S_SCAN;
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          scan_cnt <= scan_cnt + CW'(1);
          if (scan_cnt + CW'(1) == point_count) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!rd_v && !v1 && !v2 && !v3) begin
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (c_valid[1]) begin
            cur_found <= 1'b1;
            cur_last  <= !c_valid[2];
            state     <= S_WAIT;
          end else begin
            cur_found <= 1'b0;
            cur_last  <= 1'b1;
            state     <= S_SEND;
          end
        end
        S_WAIT: begin
          if (sq_done) begin
            state <= S_SEND;
          end
        end
        S_SEND: begin
          if (out_free) begin
            if (cur_last) begin
              state <= S_IDLE;
            end else begin
              rank_cnt <= rank_cnt + RW'(1);
              state    <= S_ROOT;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_ROOT) begin
      cur_idx <= c_valid[1] ? c_idx[1] : '0;
    end
  end

  assign idx_wide  = {{ngps_pkg::INDEX_W{1'b0}}, cur_idx};
  assign rank_wide = {{ngps_pkg::RANK_W{1'b0}}, rank_cnt};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == S_SEND) && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_SEND) && out_free) begin
      out_idx   <= idx_wide[ngps_pkg::INDEX_W-1:0];
      out_dist  <= cur_found ? sq_root : '0;
      out_rank  <= rank_wide[ngps_pkg::RANK_W-1:0];
      out_found <= cur_found;
      out_last  <= cur_last;
    end
  end

  assign m_axis_tdata = {4'b0000, out_rank, out_dist, out_idx};
  assign m_axis_tuser = out_found;
  assign m_axis_tlast = out_last;

  assign in_scan      = (state == S_SCAN) || (state == S_DRAIN);
  assign cells_packed = (cell_valid & (cell_valid + MAX_NEAREST'(1))) == '0;

  `ASSERT_IMPLIES(a_cells_prefix, clk, rst, 1'b1, cells_packed)
  `ASSERT_IMPLIES(a_cells_within_k, clk, rst, in_scan, $countones(cell_valid) <= 32'(k_eff))
  `ASSERT_IMPLIES(a_root_idle, clk, rst, sq_start, !sq_busy)
  `ASSERT_NEXT(a_query_clears, clk, rst, query_start, cell_valid == '0)

endmodule
